@@ src/pidstep_pkg.sv @@
// pidstep_pkg: shared types and constants for the PID step unit.
// Holds register indexes, configuration bundle, FSM states and datapath commands.
// No dependencies.
`timescale 1ns / 1ps

package pidstep_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int GAIN_W    = 31;
	localparam int CFG_IDX_W = 3;
	localparam int OPA_W     = DATA_W + 1;
	localparam int PROD_W    = OPA_W + GAIN_W;
	localparam int TERM_W    = PROD_W - FRAC_W;
	localparam int SUM_W     = TERM_W + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_DERIV_GAIN   = 3'd2,
		REG_DEADBAND     = 3'd3,
		REG_INTEG_LIMIT  = 3'd4,
		REG_SEP_THRESH   = 3'd5,
		REG_PERIOD       = 3'd6,
		REG_DERIV_MODE   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [GAIN_W-1:0] deadband;
		logic [GAIN_W-1:0] integ_limit;
		logic [GAIN_W-1:0] sep_thresh;
		logic [GAIN_W-1:0] period;
		logic              deriv_on_meas;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_T,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MUL_PERIOD,
		MUL_PROP,
		MUL_INTEG,
		MUL_DERIV
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     calc_err;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_upd;
		logic     sum_load;
		logic     sum_add;
		logic     hist_upd;
		logic     out_load;
	} dp_cmd_t;

endpackage

@@ src/pidstep_cfg.sv @@
// pidstep_cfg: configuration register file, written through the plain write port.
// Depends on pidstep_pkg.
`timescale 1ns / 1ps

module pidstep_cfg import pidstep_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q               <= '0;
			cfg_q.period        <= GAIN_W'(65536);
			cfg_q.deriv_on_meas <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:   cfg_q.prop_gain     <= cfg_wdata;
				REG_INTEG_GAIN:  cfg_q.integ_gain    <= cfg_wdata;
				REG_DERIV_GAIN:  cfg_q.deriv_gain    <= cfg_wdata;
				REG_DEADBAND:    cfg_q.deadband      <= cfg_wdata;
				REG_INTEG_LIMIT: cfg_q.integ_limit   <= cfg_wdata;
				REG_SEP_THRESH:  cfg_q.sep_thresh    <= cfg_wdata;
				REG_PERIOD:      cfg_q.period        <= cfg_wdata;
				REG_DERIV_MODE:  cfg_q.deriv_on_meas <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/pidstep_ctrl.sv @@
// pidstep_ctrl: sequencer for one PID step; issues datapath commands, owns handshakes.
// Depends on pidstep_pkg.
`timescale 1ns / 1ps

module pidstep_ctrl import pidstep_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_ERR;
			ST_ERR:   state_nxt = ST_MUL_T;
			ST_MUL_T: state_nxt = ST_MUL_P;
			ST_MUL_P: state_nxt = ST_MUL_I;
			ST_MUL_I: state_nxt = ST_MUL_D;
			ST_MUL_D: state_nxt = ST_SUM;
			ST_SUM:   state_nxt = ST_OUT;
			ST_OUT:   if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_ERR: begin
				cmd.calc_err = 1'b1;
			end
			ST_MUL_T: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PERIOD;
			end
			ST_MUL_P: begin
				cmd.acc_upd = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PROP;
			end
			ST_MUL_I: begin
				cmd.sum_load = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_INTEG;
			end
			ST_MUL_D: begin
				cmd.sum_add  = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_DERIV;
				cmd.hist_upd = 1'b1;
			end
			ST_SUM: begin
				cmd.sum_add = 1'b1;
			end
			ST_OUT: begin
				cmd.out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/pidstep_dp.sv @@
// pidstep_dp: PID datapath: dead zone, clamp, shared gain multiplier, accumulator, output.
// Depends on pidstep_pkg; driven by pidstep_ctrl commands.
`timescale 1ns / 1ps

module pidstep_dp import pidstep_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  cfg_t              cfg,
	input  logic [DATA_W-1:0] target,
	input  logic [DATA_W-1:0] measured,
	output logic [DATA_W-1:0] drive
);

	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
		lo = ~hi;
		if (x > hi)
			sat_data = DATA_W'(hi);
		else if (x < lo)
			sat_data = DATA_W'(lo);
		else
			sat_data = DATA_W'(x);
	endfunction

	// per-item payload
	logic signed [DATA_W-1:0] meas_q;
	logic signed [DATA_W:0]   raw_q;
	logic signed [DATA_W-1:0] err_q;
	logic                     sep_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [DATA_W-1:0]        drive_q;

	// controller state
	logic signed [DATA_W-1:0] accum_q;
	logic signed [DATA_W-1:0] last_meas_q;
	logic signed [DATA_W-1:0] last_err_q;

	// error stage
	logic [DATA_W:0]          mag;
	logic [DATA_W:0]          dz;
	logic [DATA_W:0]          sep_mag;
	logic signed [DATA_W+1:0] err_full;
	logic signed [DATA_W-1:0] err_sat;
	logic                     sep_hit;
	logic signed [DATA_W-1:0] lim;
	logic signed [DATA_W-1:0] accum_clamped;

	always_comb begin
		dz  = (DATA_W+1)'(cfg.deadband);
		mag = raw_q[DATA_W] ? (DATA_W+1)'(-raw_q) : (DATA_W+1)'(raw_q);
		if (mag <= dz)
			err_full = '0;
		else if (raw_q[DATA_W])
			err_full = (DATA_W+2)'(raw_q) + $signed({1'b0, dz});
		else
			err_full = (DATA_W+2)'(raw_q) - $signed({1'b0, dz});
		err_sat = sat_data(SUM_W'(err_full));
		sep_mag = (mag < dz) ? '0 : mag;
		sep_hit = (cfg.sep_thresh != '0) && (sep_mag >= (DATA_W+1)'(cfg.sep_thresh));

		lim           = $signed(DATA_W'(cfg.integ_limit));
		accum_clamped = accum_q;
		if (cfg.integ_limit != '0) begin
			if (accum_q > lim)
				accum_clamped = lim;
			else if (accum_q < -lim)
				accum_clamped = -lim;
		end
	end

	// shared multiplier
	logic signed [OPA_W-1:0]  mul_a;
	logic [GAIN_W-1:0]        mul_g;
	logic signed [PROD_W-1:0] mul_full;
	logic signed [TERM_W-1:0] term;

	always_comb begin
		case (cmd.mul_sel)
			MUL_PERIOD: begin
				mul_a = OPA_W'(err_q);
				mul_g = cfg.period;
			end
			MUL_PROP: begin
				mul_a = OPA_W'(err_q);
				mul_g = cfg.prop_gain;
			end
			MUL_INTEG: begin
				mul_a = OPA_W'(accum_q);
				mul_g = cfg.integ_gain;
			end
			MUL_DERIV: begin
				if (cfg.deriv_on_meas)
					mul_a = OPA_W'(last_meas_q) - OPA_W'(meas_q);
				else
					mul_a = OPA_W'(err_q) - OPA_W'(last_err_q);
				mul_g = cfg.deriv_gain;
			end
			default: begin
				mul_a = '0;
				mul_g = '0;
			end
		endcase
		mul_full = mul_a * $signed({1'b0, mul_g});
		term     = prod_q[PROD_W-1:FRAC_W];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			meas_q <= $signed(measured);
			raw_q  <= (DATA_W+1)'($signed(target)) - (DATA_W+1)'($signed(measured));
		end
		if (cmd.calc_err) begin
			err_q <= err_sat;
			sep_q <= sep_hit;
		end
		if (cmd.mul_en)
			prod_q <= mul_full;
		if (cmd.sum_load)
			sum_q <= SUM_W'(term);
		else if (cmd.sum_add)
			sum_q <= sum_q + SUM_W'(term);
		if (cmd.out_load)
			drive_q <= sat_data(sum_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q     <= '0;
			last_meas_q <= '0;
			last_err_q  <= '0;
		end else begin
			if (cmd.calc_err)
				accum_q <= accum_clamped;
			else if (cmd.acc_upd)
				accum_q <= sep_q ? '0 : sat_data(SUM_W'(accum_q) + SUM_W'(term));
			if (cmd.hist_upd) begin
				last_meas_q <= meas_q;
				last_err_q  <= err_q;
			end
		end
	end

	assign drive = drive_q;

endmodule

@@ src/pid_controller_step_unit.sv @@
// Positional PID step unit, signed Q16.16: one drive value per target/measured request.
// The four products share a single 33x31 multiplier in sequence, so a new request is
// accepted only once the sequencer is back in idle after loading the previous result.
// A stalled output holds the sequencer in its final step until the previous result is taken.
// arst_n clears integral and history state and loads register defaults.
`timescale 1ns / 1ps

module pid_controller_step_unit import pidstep_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [2*DATA_W-1:0]    s_axis_tdata,  // [31:0] target, [63:32] measured
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [DATA_W-1:0]      m_axis_tdata,  // [31:0] drive
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [GAIN_W-1:0]      cfg_wdata
);

	cfg_t    cfg;
	dp_cmd_t cmd;

	pidstep_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pidstep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	pidstep_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.target   (s_axis_tdata[DATA_W-1:0]),
		.measured (s_axis_tdata[2*DATA_W-1:DATA_W]),
		.drive    (m_axis_tdata)
	);

endmodule

@@ src/pidstep_checker.sv @@
// pidstep_checker: port-level assertions for the PID step unit, bound to the top level.
// Depends on pidstep_pkg.
`timescale 1ns / 1ps

module pidstep_checker import pidstep_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [DATA_W-1:0]    m_axis_tdata
);

	logic in_req;
	assign in_req = s_axis_tvalid && s_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_req |=> !s_axis_tready ##1 !s_axis_tready)
		else $error("input taken again while a step is in progress");

	a_out_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("output raised without a step in its last phase");

endmodule

bind pid_controller_step_unit pidstep_checker u_pidstep_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for pid_controller_step_unit: streamed target/measured requests
// against a cycle-free PID predictor, with random idling, a long output stall and reg phases.
// Depends on pidstep_pkg and the unit RTL.
`timescale 1ns / 1ps

module testbench;
	import pidstep_pkg::*;

	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS   = 50;
	localparam int PHASES        = 8;

	typedef struct packed {
		logic signed [DATA_W-1:0] measured;
		logic signed [DATA_W-1:0] target;
	} sample_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [2*DATA_W-1:0]   s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [DATA_W-1:0]     m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [GAIN_W-1:0]     cfg_wdata = '0;

	sample_t               pending_samples[$];
	logic [DATA_W-1:0]     expected_drive[$];
	int                    fail_count = 0;
	int                    results_seen = 0;
	bit                    req_taken = 1'b0;
	bit                    resp_taken = 1'b0;

	// predictor state
	cfg_t                  regs_model;
	longint                integ_acc = 0;
	longint                prev_meas = 0;
	longint                prev_err = 0;

	pid_controller_step_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("pid_controller_step_unit verification failed");
		$finish;
	end

	function automatic longint sat_q(longint x);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (DATA_W - 1)) - 1;
		lo = -hi - 1;
		return (x > hi) ? hi : ((x < lo) ? lo : x);
	endfunction

	// floor(a * g / 2^FRAC_W), exact
	function automatic longint scale_q(longint a, longint g);
		logic signed [127:0] wa;
		logic signed [127:0] wg;
		logic signed [127:0] prod;
		wa = a;
		wg = g;
		prod = wa * wg;
		return longint'(prod >>> FRAC_W);
	endfunction

	function automatic logic [DATA_W-1:0] pid_predict(sample_t s);
		longint t, m, raw, mag, dz, err, p, i, d, diff, sum, lim;
		t = longint'($signed(s.target));
		m = longint'($signed(s.measured));
		raw = t - m;
		mag = (raw < 0) ? -raw : raw;
		dz = regs_model.deadband;
		if (mag <= dz) begin
			err = 0;
			if (mag < dz)
				mag = 0;
		end else begin
			err = (raw > 0) ? raw - dz : raw + dz;
		end
		err = sat_q(err);
		p = scale_q(err, regs_model.prop_gain);
		if (regs_model.integ_limit != 0) begin
			lim = regs_model.integ_limit;
			if (integ_acc > lim)
				integ_acc = lim;
			if (integ_acc < -lim)
				integ_acc = -lim;
		end
		if (regs_model.sep_thresh != 0 && mag >= longint'(regs_model.sep_thresh)) begin
			integ_acc = 0;
			i = 0;
		end else begin
			integ_acc = sat_q(integ_acc + scale_q(err, regs_model.period));
			i = scale_q(integ_acc, regs_model.integ_gain);
		end
		if (regs_model.deriv_on_meas)
			diff = prev_meas - m;
		else
			diff = err - prev_err;
		d = scale_q(diff, regs_model.deriv_gain);
		sum = sat_q(p + i + d);
		prev_meas = m;
		prev_err = err;
		return sum[DATA_W-1:0];
	endfunction

	// request side
	always @(negedge clk) begin
		int      gap;
		int      offered;
		bit      quiet_in;
		sample_t s;
		if (s_axis_tvalid && !req_taken) begin
			// hold current request
		end else begin
			if (s_axis_tvalid)
				gap = quiet_in ? 0 : $urandom_range(0, 13);
			if (gap == 0 && pending_samples.size() > 0) begin
				s = pending_samples.pop_front();
				s_axis_tdata <= s;
				s_axis_tvalid <= 1'b1;
				offered++;
				if (offered % 40 == 0)
					quiet_in = ($urandom_range(0, 3) == 0);
			end else begin
				s_axis_tvalid <= 1'b0;
				if (gap > 0)
					gap--;
			end
		end
	end

	// result side, with one long hold-off to back the unit up
	always @(negedge clk) begin
		int stall_left;
		int hold_left;
		bit hold_done;
		bit quiet_out;
		if (!hold_done && results_seen >= 150 && pending_samples.size() > 10) begin
			hold_left = 400;
			hold_done = 1'b1;
		end
		if (resp_taken) begin
			stall_left = quiet_out ? 0 : $urandom_range(0, 13);
			if (results_seen % 40 == 0)
				quiet_out = ($urandom_range(0, 3) == 0);
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		logic [DATA_W-1:0] want;
		req_taken = s_axis_tvalid && s_axis_tready;
		resp_taken = m_axis_tvalid && m_axis_tready;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_PROP_GAIN:   regs_model.prop_gain = cfg_wdata;
					REG_INTEG_GAIN:  regs_model.integ_gain = cfg_wdata;
					REG_DERIV_GAIN:  regs_model.deriv_gain = cfg_wdata;
					REG_DEADBAND:    regs_model.deadband = cfg_wdata;
					REG_INTEG_LIMIT: regs_model.integ_limit = cfg_wdata;
					REG_SEP_THRESH:  regs_model.sep_thresh = cfg_wdata;
					REG_PERIOD:      regs_model.period = cfg_wdata;
					REG_DERIV_MODE:  regs_model.deriv_on_meas = cfg_wdata[0];
					default: ;
				endcase
			end
			if (req_taken)
				expected_drive.push_back(pid_predict(sample_t'(s_axis_tdata)));
			if (resp_taken) begin
				results_seen++;
				if (expected_drive.size() == 0) begin
					$error("drive: unexpected result %0d, no request outstanding",
						$signed(m_axis_tdata));
					fail_count++;
				end else begin
					want = expected_drive.pop_front();
					if (m_axis_tdata !== want) begin
						$error("drive: expected %0d, got %0d", $signed(want),
							$signed(m_axis_tdata));
						fail_count++;
					end
				end
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [GAIN_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
			logic [GAIN_W-1:0] kd, logic [GAIN_W-1:0] dz, logic [GAIN_W-1:0] lim,
			logic [GAIN_W-1:0] sep, logic [GAIN_W-1:0] per, logic mode);
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		write_reg(REG_DERIV_GAIN, kd);
		write_reg(REG_DEADBAND, dz);
		write_reg(REG_INTEG_LIMIT, lim);
		write_reg(REG_SEP_THRESH, sep);
		write_reg(REG_PERIOD, per);
		write_reg(REG_DERIV_MODE, {{(GAIN_W-1){1'b0}}, mode});
	endtask

	task automatic queue_sample(logic [DATA_W-1:0] t, logic [DATA_W-1:0] m);
		sample_t s;
		s.target = t;
		s.measured = m;
		pending_samples.push_back(s);
	endtask

	// wait until every request is answered, then let the pipeline drain
	task automatic settle();
		while (pending_samples.size() != 0 || s_axis_tvalid || expected_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return GAIN_W'($urandom_range(0, 32'h7FFF_FFFF));
			default: return GAIN_W'($urandom_range(0, 32'h0003_0000));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_span(int unsigned typical);
		case ($urandom_range(0, 7))
			0, 1: return '0;
			2: return '1;
			3: return GAIN_W'($urandom_range(0, 32'h7FFF_FFFF));
			default: return GAIN_W'($urandom_range(1, typical));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_level();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	initial begin
		int     ph;
		int     k;
		int     tgt;
		int     lvl;
		longint step;
		regs_model = '{prop_gain: '0, integ_gain: '0, deriv_gain: '0, deadband: '0,
			integ_limit: '0, sep_thresh: '0, period: 31'd65536, deriv_on_meas: 1'b1};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// dead zone edges, separation edge, limit clamp, extremes
		write_all(31'h0001_0000, 31'h0000_8000, 31'h0000_4000, 31'h0001_0000,
			31'h0040_0000, 31'h0080_0000, 31'h0001_0000, 1'b1);
		queue_sample(32'h0000_0000, 32'h0000_0000);
		queue_sample(32'h0001_0000, 32'h0000_0000);
		queue_sample(32'h0001_0001, 32'h0000_0000);
		queue_sample(32'h0000_0000, 32'h0001_0000);
		queue_sample(32'h0000_0000, 32'h0001_0001);
		queue_sample(32'h0000_8000, 32'h0000_0000);
		queue_sample(32'h0080_0000, 32'h0000_0000);
		queue_sample(32'h007F_FFFF, 32'h0000_0000);
		queue_sample(32'h0030_0000, 32'h0000_0000);
		queue_sample(32'h0030_0000, 32'h0000_0000);
		queue_sample(32'h0030_0000, 32'h0000_0000);
		queue_sample(32'hFFD0_0000, 32'h0000_0000);
		queue_sample(32'h7FFF_FFFF, 32'h8000_0000);
		queue_sample(32'h8000_0000, 32'h7FFF_FFFF);
		queue_sample(32'h8000_0000, 32'h8000_0000);
		queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_sample(32'hFFFF_FFFF, 32'h0000_0001);
		settle();

		// all gains at maximum, derivative on error, no dead zone / limit / separation
		write_all('1, '1, '1, '0, '0, '0, '1, 1'b0);
		queue_sample(32'h7FFF_FFFF, 32'h8000_0000);
		queue_sample(32'h8000_0000, 32'h7FFF_FFFF);
		queue_sample(32'h0000_0100, 32'h0000_0000);
		queue_sample(32'h0000_0000, 32'h0000_0100);
		settle();

		// everything zero but the derivative mode (on measurement)
		write_all('0, '0, '0, '0, '0, '0, '0, 1'b1);
		queue_sample(32'h1234_5678, 32'h8765_4321);
		queue_sample(32'h8000_0000, 32'h7FFF_FFFF);
		settle();

		// random phases: mostly a measurement tracking its setpoint, some noise
		tgt = rand_level();
		lvl = rand_level();
		for (ph = 0; ph < PHASES; ph++) begin
			write_reg(REG_PROP_GAIN, pick_gain());
			write_reg(REG_INTEG_GAIN, pick_gain());
			write_reg(REG_DERIV_GAIN, pick_gain());
			write_reg(REG_DEADBAND, pick_span(32'h0002_0000));
			write_reg(REG_INTEG_LIMIT, pick_span(32'h1000_0000));
			write_reg(REG_SEP_THRESH, pick_span(32'h0100_0000));
			write_reg(REG_PERIOD, ($urandom_range(0, 2) == 0) ? 31'h0001_0000 :
				pick_span(32'h0002_0000));
			write_reg(REG_DERIV_MODE, GAIN_W'($urandom_range(0, 1)));
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 6) == 0) begin
					queue_sample($urandom, ($urandom_range(0, 1) == 0) ? $urandom : rand_level());
				end else begin
					if ($urandom_range(0, 9) == 0)
						tgt = rand_level();
					step = (longint'(tgt) - longint'(lvl)) / 4;
					lvl = int'(longint'(lvl) + step + $urandom_range(0, 512) - 256);
					queue_sample(tgt, lvl);
				end
			end
			settle();
		end

		if (expected_drive.size() != 0) begin
			$error("drive: %0d expected results never arrived", expected_drive.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("pid_controller_step_unit verification clean");
		else
			$display("pid_controller_step_unit verification failed");
		$finish;
	end

endmodule
